// ===== rtl/core/osrt_pkg.sv =====
package osrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int MAX_RELAYS_DEF    = 11;

    localparam int ACT_W  = 2;
    localparam int NODE_W = 16;
    localparam int CNT_W  = 4;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_STAGE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CONSUME = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ARG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NODE_W-1:0] destination;
        logic [CNT_W-1:0]  relay_count;
        logic [CNT_W-1:0]  relay_position;
        logic [NODE_W-1:0] relay_value;
        logic [NODE_W-1:0] random_value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  route_length;
        logic [NODE_W-1:0] relay_out;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [NODE_W-1:0] destination;
        logic [CNT_W-1:0]  relay_count;
    } t_meta;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_COPY,
        S_EMIT,
        S_RESP
    } t_state;

endpackage

// ===== rtl/core/osrt_mod.sv =====
module osrt_mod
    import osrt_pkg::*;
#(
    parameter int DIVISOR = TABLE_ENTRIES_DEF,
    parameter int RW      = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NODE_W-1:0] i_value,
    output logic [RW-1:0]     o_rem
);

    localparam int LG  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SH  = NODE_W + LG;
    localparam int MW  = NODE_W + 2;
    localparam int PRW = NODE_W + MW;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0]     RECIP = MW'(RECIP_VAL);
    localparam logic [NODE_W-1:0] DIV   = NODE_W'(DIVISOR);

    logic [NODE_W-1:0] r_val;
    logic [NODE_W-1:0] r_quo;
    logic [RW-1:0]     r_rem;
    logic [1:0]        r_left;
    logic [PRW-1:0]    prod;
    logic [NODE_W-1:0] n_quo;
    logic [RW-1:0]     n_rem;

    always_comb begin
        prod  = PRW'(r_val) * PRW'(RECIP);
        n_quo = NODE_W'(prod >> SH);
        n_rem = RW'(r_val - r_quo * DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_start) begin
            r_left <= 2'd2;
        end else if (r_left != 2'd0) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end else if (r_left == 2'd2) begin
            r_quo <= n_quo;
        end else if (r_left == 2'd1) begin
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

// ===== rtl/core/one_shot_source_route_table.sv =====
// Stage, bad count, unknown action: straight to the response step, which registers the result.
// Commit: table scan, pick step, copy of relay_count staged relays, then a response step.
// Consume: the same scan and pick, then one relay per cycle while the output is not stalled.
// A consume miss or empty route gives one response. One item at a time; output stalls hold it.
// Reset (synchronous, active low) clears active flags and staging valid bits at once.
module one_shot_source_route_table
    import osrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_RELAYS    = MAX_RELAYS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PW = (MAX_RELAYS > 1) ? $clog2(MAX_RELAYS) : 1;
    localparam int RD = TABLE_ENTRIES * MAX_RELAYS;
    localparam int AW = (RD > 1) ? $clog2(RD) : 1;

    localparam logic [IW-1:0]  LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W:0] MAX_C    = (CNT_W + 1)'(MAX_RELAYS);
    localparam logic [AW-1:0]  MAX_A    = AW'(MAX_RELAYS);

    t_state r_state, n_state;

    t_meta             m_meta [TABLE_ENTRIES];
    logic [NODE_W-1:0] m_relays [RD];
    logic [NODE_W-1:0] m_stage [MAX_RELAYS];

    logic [TABLE_ENTRIES-1:0] r_active;
    logic [MAX_RELAYS-1:0]    r_stage_vld;

    t_meta             r_meta_q;
    logic [NODE_W-1:0] r_rel_q;
    logic [NODE_W-1:0] r_stg_q;
    logic              r_stg_q_vld;

    logic [ACT_W-1:0]  r_act;
    logic [NODE_W-1:0] r_dest;
    logic [CNT_W-1:0]  r_cnt;
    logic [STAT_W-1:0] r_status;

    logic [IW-1:0] r_rd_idx;
    logic          r_rd_done;
    logic          r_chk_vld;
    logic [IW-1:0] r_chk_idx;
    logic          r_hit;
    logic [IW-1:0] r_slot;
    logic          r_free_vld;
    logic [IW-1:0] r_free_idx;

    logic [AW-1:0]    r_base;
    logic [CNT_W-1:0] r_k;
    logic             r_cp_vld;
    logic [AW-1:0]    r_cp_addr;
    logic             r_pend;

    logic r_out_vld;
    t_out r_out;

    logic [IW-1:0] mod_rem;

    logic          acc;
    logic          out_free;
    logic          pos_ok;
    logic          cnt_ok;
    logic          scan_rd;
    logic          chk_hit;
    logic          chk_free;
    logic          scan_end;
    logic [IW-1:0] pick_slot;
    logic [AW-1:0] pick_base;
    logic          cp_issue;
    logic          cp_end;
    logic          em_load;
    logic          em_issue;
    logic          em_end;
    logic          resp_load;

    osrt_mod #(
        .DIVISOR (TABLE_ENTRIES),
        .RW      (IW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc),
        .i_value (i_in_data.random_value),
        .o_rem   (mod_rem)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign acc         = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        pos_ok    = ({1'b0, i_in_data.relay_position} < MAX_C);
        cnt_ok    = ({1'b0, i_in_data.relay_count} <= MAX_C);
        scan_rd   = (r_state == S_SCAN) && !r_rd_done;
        chk_hit   = (r_state == S_SCAN) && r_chk_vld && r_active[r_chk_idx]
                    && (r_meta_q.destination == r_dest);
        chk_free  = (r_state == S_SCAN) && r_chk_vld && !r_active[r_chk_idx];
        scan_end  = chk_hit || ((r_state == S_SCAN) && r_chk_vld && (r_chk_idx == LAST_IDX));
        pick_slot = r_hit ? r_slot : (r_free_vld ? r_free_idx : mod_rem);
        pick_base = AW'(pick_slot) * MAX_A;
        cp_issue  = (r_state == S_COPY) && (r_k != r_cnt);
        cp_end    = (r_state == S_COPY) && (r_k == r_cnt) && !r_cp_vld;
        em_load   = (r_state == S_EMIT) && r_pend && out_free;
        em_issue  = (r_state == S_EMIT) && (!r_pend || em_load) && (r_k != r_cnt);
        em_end    = em_load && (r_k == r_cnt);
        resp_load = (r_state == S_RESP) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if ((i_in_data.action == ACT_COMMIT && cnt_ok)
                        || i_in_data.action == ACT_CONSUME) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_act == ACT_COMMIT) begin
                    n_state = S_COPY;
                end else if (r_hit && r_cnt != '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_COPY: begin
                if (cp_end) begin
                    n_state = S_RESP;
                end
            end
            S_EMIT: begin
                if (em_end) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (resp_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_stage_vld <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc && i_in_data.action == ACT_STAGE && pos_ok) begin
                r_stage_vld[i_in_data.relay_position[PW-1:0]] <= 1'b1;
            end
            if (r_state == S_PICK && r_act == ACT_CONSUME && r_hit) begin
                r_active[r_slot] <= 1'b0;
            end
            if (cp_end) begin
                r_active[r_slot] <= 1'b1;
            end
            if (em_load || resp_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act      <= i_in_data.action;
            r_dest     <= i_in_data.destination;
            r_cnt      <= i_in_data.relay_count;
            r_rd_idx   <= '0;
            r_rd_done  <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            unique case (i_in_data.action)
                ACT_STAGE:   r_status <= pos_ok ? ST_OK : ST_BAD_ARG;
                ACT_COMMIT:  r_status <= cnt_ok ? ST_OK : ST_BAD_ARG;
                ACT_CONSUME: r_status <= ST_OK;
                default:     r_status <= ST_BAD_ARG;
            endcase
        end
        if (r_state == S_SCAN) begin
            r_chk_vld <= scan_rd;
            r_chk_idx <= r_rd_idx;
            if (scan_rd) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_done <= 1'b1;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (chk_hit) begin
                r_hit  <= 1'b1;
                r_slot <= r_chk_idx;
                if (r_act == ACT_CONSUME) begin
                    r_cnt <= r_meta_q.relay_count;
                end
            end
            if (chk_free) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end
        if (r_state == S_PICK) begin
            r_slot   <= pick_slot;
            r_base   <= pick_base;
            r_k      <= '0;
            r_cp_vld <= 1'b0;
            r_pend   <= 1'b0;
            if (r_act == ACT_CONSUME && !r_hit) begin
                r_status <= ST_NO_ROUTE;
            end
        end
        if (r_state == S_COPY) begin
            r_cp_vld  <= cp_issue;
            r_cp_addr <= r_base + AW'(r_k);
            if (cp_issue) begin
                r_k <= r_k + 1'b1;
            end
        end
        if (r_state == S_EMIT) begin
            if (em_issue) begin
                r_k    <= r_k + 1'b1;
                r_pend <= 1'b1;
            end else if (em_load) begin
                r_pend <= 1'b0;
            end
        end
        if (em_load) begin
            r_out.status       <= ST_OK;
            r_out.route_length <= r_cnt;
            r_out.relay_out    <= r_rel_q;
            r_out.last         <= (r_k == r_cnt);
        end else if (resp_load) begin
            r_out.status       <= r_status;
            r_out.route_length <= '0;
            r_out.relay_out    <= '0;
            r_out.last         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_rd) begin
            r_meta_q <= m_meta[r_rd_idx];
        end
        if (cp_end) begin
            m_meta[r_slot] <= '{destination: r_dest, relay_count: r_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_in_data.action == ACT_STAGE && pos_ok) begin
            m_stage[i_in_data.relay_position[PW-1:0]] <= i_in_data.relay_value;
        end
        if (cp_issue) begin
            r_stg_q     <= m_stage[r_k[PW-1:0]];
            r_stg_q_vld <= r_stage_vld[r_k[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cp_vld) begin
            m_relays[r_cp_addr] <= r_stg_q_vld ? r_stg_q : '0;
        end
        if (em_issue) begin
            r_rel_q <= m_relays[r_base + AW'(r_k)];
        end
    end

endmodule

// ===== rtl/core/osrt_checker.sv =====
module osrt_checker
    import osrt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken before the first item finished");

    a_no_accept_mid_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input taken while a route is still being emitted");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK
        |-> o_out_data.route_length == '0 && o_out_data.relay_out == '0
            && o_out_data.last)
        else $error("failed result carries route data");

endmodule

bind one_shot_source_route_table osrt_checker u_osrt_checker (.*);

// ===== tb/one_shot_source_route_table_tb.sv =====
module one_shot_source_route_table_tb;
    import osrt_pkg::*;

    localparam int N_SLOTS    = TABLE_ENTRIES_DEF;
    localparam int N_HOPS     = MAX_RELAYS_DEF;
    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 64;
    localparam int PRESSURE_AT  = 60;
    localparam int PRESSURE_LEN = 300;
    localparam int PRINT_CAP  = 50;

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    one_shot_source_route_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    bit                slot_live [N_SLOTS];
    logic [NODE_W-1:0] slot_dest [N_SLOTS];
    logic [CNT_W-1:0]  slot_len  [N_SLOTS];
    logic [NODE_W-1:0] slot_hops [N_SLOTS][N_HOPS];
    logic [NODE_W-1:0] staged_hops [N_HOPS];

    t_out due_replies[$];
    t_row plan[$];
    logic [NODE_W-1:0] dest_pool [12];

    int err_count    = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int calm_left    = 0;
    int src_calm     = 0;
    int sink_roll;
    bit pressure_done = 1'b0;

    task automatic flag_error(input string msg);
        if (err_count < PRINT_CAP)
            $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic apply_route_item(input t_in it, input bit typed, input t_out want);
        t_out r;
        t_out outs[$];
        int slot;
        int n;
        bit hit;
        r = '0;
        r.last = 1'b1;
        hit = 1'b0;
        case (it.action)
            ACT_STAGE: begin
                if (it.relay_position >= N_HOPS) begin
                    r.status = ST_BAD_ARG;
                end else begin
                    staged_hops[it.relay_position] = it.relay_value;
                    r.status = ST_OK;
                end
                outs.push_back(r);
            end
            ACT_COMMIT: begin
                if (it.relay_count > N_HOPS) begin
                    r.status = ST_BAD_ARG;
                end else begin
                    slot = it.random_value % N_SLOTS;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        if (!slot_live[i]) begin
                            slot = i;
                        end else if (slot_dest[i] == it.destination) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int k = 0; k < it.relay_count; k++)
                        slot_hops[slot][k] = staged_hops[k];
                    slot_dest[slot] = it.destination;
                    slot_len[slot]  = it.relay_count;
                    slot_live[slot] = 1'b1;
                    r.status = ST_OK;
                end
                outs.push_back(r);
            end
            ACT_CONSUME: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (slot_live[i] && slot_dest[i] == it.destination) begin
                        hit = 1'b1;
                        slot_live[i] = 1'b0;
                        n = slot_len[i];
                        r.status = ST_OK;
                        if (n == 0) begin
                            outs.push_back(r);
                        end else begin
                            for (int k = 0; k < n; k++) begin
                                r.route_length = CNT_W'(n);
                                r.relay_out    = slot_hops[i][k];
                                r.last         = (k == n - 1);
                                outs.push_back(r);
                            end
                        end
                        break;
                    end
                end
                if (!hit) begin
                    r.status = ST_NO_ROUTE;
                    outs.push_back(r);
                end
            end
            default: begin
                r.status = ST_BAD_ARG;
                outs.push_back(r);
            end
        endcase
        if (typed)
            due_replies.push_back(want);
        else
            foreach (outs[j]) due_replies.push_back(outs[j]);
    endtask

    function automatic t_row step_row(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] dest,
                                      input logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] pos,
                                      input logic [NODE_W-1:0] val, input logic [NODE_W-1:0] rnd,
                                      input bit typed, input logic [STAT_W-1:0] st);
        t_row r;
        r.item.action         = act;
        r.item.destination    = dest;
        r.item.relay_count    = cnt;
        r.item.relay_position = pos;
        r.item.relay_value    = val;
        r.item.random_value   = rnd;
        r.typed               = typed;
        r.want.status         = st;
        r.want.route_length   = '0;
        r.want.relay_out      = '0;
        r.want.last           = 1'b1;
        return r;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int pick;
        pick = $urandom_range(99);
        it.destination    = ($urandom_range(9) == 0) ? NODE_W'($urandom)
                                                     : dest_pool[$urandom_range(11)];
        it.relay_count    = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(15))
                                                     : CNT_W'($urandom_range(N_HOPS));
        it.relay_position = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(15))
                                                     : CNT_W'($urandom_range(N_HOPS - 1));
        it.relay_value    = NODE_W'($urandom);
        it.random_value   = NODE_W'($urandom);
        if (pick < 40)
            it.action = ACT_STAGE;
        else if (pick < 65)
            it.action = ACT_COMMIT;
        else if (pick < 95)
            it.action = ACT_CONSUME;
        else
            it.action = ACT_UNKNOWN;
        return it;
    endfunction

    task automatic offer_item(input t_in it, input bit typed, input t_out want);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        apply_route_item(it, typed, want);
        @(negedge i_clk);
    endtask

    task automatic source_gap();
        int g;
        int roll;
        g = 0;
        if (src_calm > 0) begin
            src_calm--;
        end else begin
            roll = $urandom_range(99);
            if (roll < 4)
                src_calm = $urandom_range(30, 10);
            else if (roll < 40)
                g = 0;
            else if (roll < 94)
                g = $urandom_range(3, 1);
            else
                g = $urandom_range(40, 15);
        end
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // hold off the sink at random, once for a long stretch
    always @(negedge i_clk) begin
        if (!pressure_done && results_seen >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            stall_left = PRESSURE_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            i_out_ready <= 1'b1;
        end else begin
            sink_roll = $urandom_range(99);
            if (sink_roll < 5)
                calm_left = $urandom_range(80, 20);
            else if (sink_roll < 8)
                stall_left = $urandom_range(40, 15);
            else if (sink_roll < 30)
                stall_left = $urandom_range(3, 1);
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (due_replies.size() == 0) begin
                flag_error($sformatf("unexpected transfer %h", o_out_data));
            end else begin
                want = due_replies.pop_front();
                if (o_out_data.status !== want.status)
                    flag_error($sformatf("status got %0d expected %0d",
                                         o_out_data.status, want.status));
                if (o_out_data.route_length !== want.route_length)
                    flag_error($sformatf("route_length got %0d expected %0d",
                                         o_out_data.route_length, want.route_length));
                if (o_out_data.relay_out !== want.relay_out)
                    flag_error($sformatf("relay_out got %h expected %h",
                                         o_out_data.relay_out, want.relay_out));
                if (o_out_data.last !== want.last)
                    flag_error($sformatf("last got %0d expected %0d",
                                         o_out_data.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        foreach (staged_hops[i]) staged_hops[i] = '0;
        foreach (dest_pool[i]) dest_pool[i] = NODE_W'($urandom);

        plan.push_back(step_row(ACT_CONSUME, 16'h0000,  0,  0, 16'h0000, 16'h0000, 1, ST_NO_ROUTE));
        plan.push_back(step_row(ACT_STAGE,   16'h0000,  0, 15, 16'hFFFF, 16'h0000, 1, ST_BAD_ARG));
        plan.push_back(step_row(ACT_COMMIT,  16'h0005, 15,  0, 16'h0000, 16'h0000, 1, ST_BAD_ARG));
        plan.push_back(step_row(ACT_UNKNOWN, 16'hFFFF, 15, 15, 16'hFFFF, 16'hFFFF, 1, ST_BAD_ARG));
        plan.push_back(step_row(ACT_STAGE,   16'h0000,  0,  0, 16'hFFFF, 16'h0000, 1, ST_OK));
        plan.push_back(step_row(ACT_STAGE,   16'h0000,  0, 10, 16'hA5A5, 16'h0000, 1, ST_OK));
        plan.push_back(step_row(ACT_COMMIT,  16'hFFFF, 11,  0, 16'h0000, 16'h0000, 1, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'hFFFF,  0,  0, 16'h0000, 16'h0000, 0, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'hFFFF,  0,  0, 16'h0000, 16'h0000, 1, ST_NO_ROUTE));
        plan.push_back(step_row(ACT_COMMIT,  16'h0000,  0,  0, 16'h0000, 16'h0000, 1, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'h0000,  0,  0, 16'h0000, 16'h0000, 1, ST_OK));
        plan.push_back(step_row(ACT_COMMIT,  16'h0001,  1,  0, 16'h0000, 16'h0000, 0, ST_OK));
        plan.push_back(step_row(ACT_COMMIT,  16'h0001,  2,  0, 16'h0000, 16'h0000, 0, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'h0001,  0,  0, 16'h0000, 16'h0000, 0, ST_OK));
        for (int d = 0; d < N_SLOTS; d++)
            plan.push_back(step_row(ACT_COMMIT, NODE_W'(16'h0010 + d), 3, 0, 16'h0000,
                                    NODE_W'(d), 0, ST_OK));
        plan.push_back(step_row(ACT_COMMIT,  16'h0020,  4,  0, 16'h0000, 16'hFFFF, 0, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'h0020,  0,  0, 16'h0000, 16'h0000, 0, ST_OK));
        plan.push_back(step_row(ACT_CONSUME, 16'h0017,  0,  0, 16'h0000, 16'h0000, 0, ST_OK));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            offer_item(plan[i].item, plan[i].typed, plan[i].want);
            source_gap();
        end
        repeat (N_RANDOM) begin
            offer_item(random_item(), 1'b0, '0);
            source_gap();
        end
        i_in_valid <= 1'b0;

        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
